### hdl/u8dec_pkg.sv
// Shared types and constants for the UTF-8 byte stream decoder.
// No dependencies; imported by u8dec_step and utf8_byte_stream_decoder.
`default_nettype none

package u8dec_pkg;

  localparam int unsigned CpW  = 31;
  localparam int unsigned RemW = 3;

  localparam logic [CpW-1:0] SubstChar = CpW'(63);

  // Lead byte prefix masks and payload masks
  localparam logic [7:0] Lead2Mask = 8'he0;
  localparam logic [7:0] Lead2Code = 8'hc0;
  localparam logic [7:0] Lead3Mask = 8'hf0;
  localparam logic [7:0] Lead3Code = 8'he0;
  localparam logic [7:0] Lead4Mask = 8'hf8;
  localparam logic [7:0] Lead4Code = 8'hf0;
  localparam logic [7:0] Lead5Mask = 8'hfc;
  localparam logic [7:0] Lead5Code = 8'hf8;
  localparam logic [7:0] Lead6Mask = 8'hfe;
  localparam logic [7:0] Lead6Code = 8'hfc;

  localparam logic [7:0] Pay2Mask = 8'h1f;
  localparam logic [7:0] Pay3Mask = 8'h0f;
  localparam logic [7:0] Pay4Mask = 8'h07;
  localparam logic [7:0] Pay5Mask = 8'h03;
  localparam logic [7:0] Pay6Mask = 8'h01;
  localparam logic [7:0] TailMask = 8'h3f;

  localparam logic [RemW-1:0] MaxRemaining = RemW'(5);

  typedef struct packed {
    logic             emit;
    logic             bad_lead;
    logic [CpW-1:0]   code_point;
    logic [CpW-1:0]   partial_next;
    logic [RemW-1:0]  remaining_next;
  } step_t;

endpackage

`default_nettype wire

### hdl/u8dec_step.sv
// Combinational decode of one byte against the current sequence state.
// Depends on u8dec_pkg.
`default_nettype none

module u8dec_step
  import u8dec_pkg::*;
(
  input  wire logic [7:0]      byte_i,
  input  wire logic            ascii_mode_i,
  input  wire logic [CpW-1:0]  partial_i,
  input  wire logic [RemW-1:0] remaining_i,
  output step_t                step_o
);

  logic [CpW-1:0] shifted;
  logic [CpW-1:0] byte_ext;

  assign shifted  = {partial_i[CpW-7:0], byte_i[5:0] & TailMask[5:0]};
  assign byte_ext = CpW'(byte_i);

  always_comb begin
    step_o = '0;
    if (ascii_mode_i) begin
      // drop any sequence in progress
      step_o.emit       = 1'b1;
      step_o.code_point = byte_ext;
    end else if (remaining_i != '0) begin
      step_o.remaining_next = remaining_i - RemW'(1);
      if (remaining_i == RemW'(1)) begin
        step_o.emit       = 1'b1;
        step_o.code_point = shifted;
      end else begin
        step_o.partial_next = shifted;
      end
    end else if (byte_i[7] == 1'b0) begin
      step_o.emit       = 1'b1;
      step_o.code_point = byte_ext;
    end else if ((byte_i & Lead2Mask) == Lead2Code) begin
      step_o.partial_next   = CpW'(byte_i & Pay2Mask);
      step_o.remaining_next = RemW'(1);
    end else if ((byte_i & Lead3Mask) == Lead3Code) begin
      step_o.partial_next   = CpW'(byte_i & Pay3Mask);
      step_o.remaining_next = RemW'(2);
    end else if ((byte_i & Lead4Mask) == Lead4Code) begin
      step_o.partial_next   = CpW'(byte_i & Pay4Mask);
      step_o.remaining_next = RemW'(3);
    end else if ((byte_i & Lead5Mask) == Lead5Code) begin
      step_o.partial_next   = CpW'(byte_i & Pay5Mask);
      step_o.remaining_next = RemW'(4);
    end else if ((byte_i & Lead6Mask) == Lead6Code) begin
      step_o.partial_next   = CpW'(byte_i & Pay6Mask);
      step_o.remaining_next = MaxRemaining;
    end else begin
      step_o.emit       = 1'b1;
      step_o.bad_lead   = 1'b1;
      step_o.code_point = SubstChar;
    end
  end

endmodule

`default_nettype wire

### hdl/utf8_byte_stream_decoder.sv
// UTF-8 byte stream decoder top level: input register, decode step, result register.
// Depends on u8dec_pkg and u8dec_step.
//
// Usage: bytes enter on the s_axis channel, one request per byte. Decoded
// code points leave on the m_axis channel; tuser flags an invalid lead byte
// that was replaced by '?'. Lead bytes and all but the last continuation
// byte of a sequence yield no output.
// cfg_we_i/cfg_wdata_i set ascii_mode (1 = pass bytes through); write it
// only while the block is idle.
// A byte accepted into the input register passes through the decode step to
// the result register, which drives m_axis. Throughput: one byte per cycle
// unless m_axis stalls, set by the single decode step between the registers.
// Reset clears the sequence state, the ascii_mode register and both valid
// flags. When the receiver stalls, the result register holds; the input
// register still takes one more byte, then tready falls until the result
// drains. A partly received sequence is discarded by reset.
`default_nettype none

module utf8_byte_stream_decoder
  import u8dec_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output      logic [31:0] m_axis_tdata_o,   // [30:0] code_point, [31] zero
  output      logic        m_axis_tuser_o    // [0] bad_lead
);

  logic            ascii_q;
  logic            in_valid_q;
  logic [7:0]      in_byte_q;
  logic [CpW-1:0]  partial_q;
  logic [RemW-1:0] remaining_q;
  logic            out_valid_q, out_valid_d;
  logic [CpW-1:0]  out_cp_q;
  logic            out_bad_q;
  logic            advance;
  step_t           step;

  u8dec_step u_step (
    .byte_i       (in_byte_q),
    .ascii_mode_i (ascii_q),
    .partial_i    (partial_q),
    .remaining_i  (remaining_q),
    .step_o       (step)
  );

  // move the held byte on when the result register is free or draining
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign out_valid_d     = (out_valid_q && !m_axis_tready_i) || (advance && step.emit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ascii_q     <= 1'b0;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      partial_q   <= '0;
      remaining_q <= '0;
    end else begin
      if (cfg_we_i) begin
        ascii_q <= cfg_wdata_i;
      end
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      out_valid_q <= out_valid_d;
      if (advance) begin
        partial_q   <= step.partial_next;
        remaining_q <= step.remaining_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
    end
    if (advance && step.emit) begin
      out_cp_q  <= step.code_point;
      out_bad_q <= step.bad_lead;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_cp_q};
  assign m_axis_tuser_o  = out_bad_q;

`ifndef SYNTHESIS
  a_rem_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    remaining_q <= MaxRemaining)
    else $error("sequence count out of range");

  a_bad_is_subst : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o == 32'd63))
    else $error("bad lead without substitute character");

  a_ascii_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && ascii_q) |=> (remaining_q == '0))
    else $error("pass-through left a sequence pending");

  a_emit_on_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !ascii_q && remaining_q == RemW'(1)) |=> m_axis_tvalid_o)
    else $error("completed sequence not presented");
`endif

endmodule

`default_nettype wire
